[src/assert_macros.svh]
// Assertion macros shared by the tile map vertex generator modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion on clk, disabled while arst_n is low.
`define ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error(msg);

// Condition that must never be true on any clock edge.
`define ASSERT_NEVER(label, expr, msg) \
	`ASSERT_CLK(label, !(expr), msg)

`endif

[src/tmvg_pkg.sv]
// Shared types, constants and helper functions of the tile map vertex generator.
package tmvg_pkg;

	// Parameter defaults
	localparam int unsigned DEF_MAX_MAP_TILES_ACROSS = 256;
	localparam int unsigned DEF_MAX_MAP_TILES_DOWN   = 256;
	localparam int unsigned DEF_TILE_INDEX_BITS      = 12;

	// Field widths
	localparam int unsigned CFG_W     = 9;
	localparam int unsigned CFG_IDX_W = 3;
	localparam int unsigned CORNER_W  = 3;
	localparam int unsigned POS_W     = 17;
	localparam int unsigned TEXU_W    = 17;
	localparam int unsigned TEXV_W    = 21;
	localparam int unsigned OUT_BITS  = CORNER_W + 2 * POS_W + TEXU_W + TEXV_W;
	localparam int unsigned OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

	// Geometry
	localparam int unsigned CORNERS       = 6;
	localparam logic [CORNER_W-1:0] LAST_CORNER = CORNER_W'(CORNERS - 1);
	localparam int unsigned TILE_SIZE_MAX = 256;
	localparam int unsigned TEX_ROW_MAX   = 256;

	// Register reset values
	localparam logic [CFG_W-1:0] RST_TILE_WIDTH  = 9'd16;
	localparam logic [CFG_W-1:0] RST_TILE_HEIGHT = 9'd16;
	localparam logic [CFG_W-1:0] RST_MAP_WIDTH   = 9'd16;
	localparam logic [CFG_W-1:0] RST_MAP_HEIGHT  = 9'd16;
	localparam logic [CFG_W-1:0] RST_TEX_PER_ROW = 9'd8;

	// Register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_TILE_WIDTH  = 3'd0,
		REG_TILE_HEIGHT = 3'd1,
		REG_MAP_WIDTH   = 3'd2,
		REG_MAP_HEIGHT  = 3'd3,
		REG_TEX_PER_ROW = 3'd4
	} reg_idx_t;

	// Effective (clamped) configuration
	typedef struct packed {
		logic [CFG_W-1:0] tw;
		logic [CFG_W-1:0] th;
		logic [CFG_W-1:0] mw;
		logic [CFG_W-1:0] mh;
		logic [CFG_W-1:0] tpr;
	} cfg_t;

	// Divider status
	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

	// Zero acts as one, values above hi act as hi.
	function automatic logic [CFG_W-1:0] clamp_cfg(logic [CFG_W-1:0] v, int unsigned hi);
		if (v == '0)
			return CFG_W'(1);
		if (32'(v) > hi)
			return CFG_W'(hi);
		return v;
	endfunction

	// Corner offsets: top-left, top-right, bottom-left, bottom-right, top-right, bottom-left.
	function automatic logic corner_dx(logic [CORNER_W-1:0] k);
		case (k)
			3'd1, 3'd3, 3'd4: return 1'b1;
			default:          return 1'b0;
		endcase
	endfunction

	function automatic logic corner_dy(logic [CORNER_W-1:0] k);
		case (k)
			3'd2, 3'd3, 3'd5: return 1'b1;
			default:          return 1'b0;
		endcase
	endfunction

endpackage

[src/tmvg_div.sv]
// Bit-serial restoring divider: tile number by texture tiles per row.
`include "assert_macros.svh"

module tmvg_div #(
	parameter int unsigned TILE_INDEX_BITS = tmvg_pkg::DEF_TILE_INDEX_BITS
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [TILE_INDEX_BITS-1:0]    dividend,
	input  logic [tmvg_pkg::CFG_W-1:0]    divisor,
	output logic [TILE_INDEX_BITS-1:0]    quotient,
	output logic [tmvg_pkg::CFG_W-1:0]    remainder,
	output tmvg_pkg::div_stat_t           stat
);
	import tmvg_pkg::*;

	localparam int unsigned CNT_W = $clog2(TILE_INDEX_BITS + 1);

	logic [CFG_W-1:0]           rem_q;
	logic [TILE_INDEX_BITS-1:0] quo_q;
	logic [CNT_W-1:0]           cnt_q;
	logic                       busy_q;
	logic                       done_q;

	logic [CFG_W:0]             trial;
	logic                       fits;
	logic [CFG_W:0]             diff;

	// One quotient bit per cycle
	assign trial = {rem_q, quo_q[TILE_INDEX_BITS-1]};
	assign fits  = (trial >= {1'b0, divisor});
	assign diff  = trial - {1'b0, divisor};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CNT_W'(1);
				if (cnt_q == CNT_W'(TILE_INDEX_BITS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath: shift dividend out, quotient bits in
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
		end else if (busy_q) begin
			rem_q <= fits ? diff[CFG_W-1:0] : trial[CFG_W-1:0];
			quo_q <= TILE_INDEX_BITS'({quo_q, fits});
		end
	end

	assign quotient  = quo_q;
	assign remainder = rem_q;
	assign stat.busy = busy_q;
	assign stat.done = done_q;

	`ASSERT_NEVER(a_start_while_busy, start && busy_q, "divider started while busy")
	`ASSERT_CLK(a_done_pulse, done_q |=> !done_q, "divider done held more than one cycle")
	`ASSERT_CLK(a_done_after_busy, done_q |-> $past(busy_q) && !busy_q,
		"divider done without a finished run")

endmodule

[src/tmvg_seq.sv]
// Sequencer, map counters, shared multiplier and vertex output stage.
`include "assert_macros.svh"

module tmvg_seq #(
	parameter int unsigned MAX_MAP_TILES_ACROSS = tmvg_pkg::DEF_MAX_MAP_TILES_ACROSS,
	parameter int unsigned MAX_MAP_TILES_DOWN   = tmvg_pkg::DEF_MAX_MAP_TILES_DOWN,
	parameter int unsigned TILE_INDEX_BITS      = tmvg_pkg::DEF_TILE_INDEX_BITS
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  tmvg_pkg::cfg_t                 cfg,
	// request side
	input  logic                           in_valid,
	output logic                           in_ready,
	// divider
	output logic                           div_start,
	input  tmvg_pkg::div_stat_t            div_stat,
	input  logic [TILE_INDEX_BITS-1:0]     div_quo,
	input  logic [tmvg_pkg::CFG_W-1:0]     div_rem,
	// result side
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [tmvg_pkg::CORNER_W-1:0]  corner,
	output logic [tmvg_pkg::POS_W-1:0]     pos_x,
	output logic [tmvg_pkg::POS_W-1:0]     pos_y,
	output logic [tmvg_pkg::TEXU_W-1:0]    tex_u,
	output logic [tmvg_pkg::TEXV_W-1:0]    tex_v,
	output logic                           last_of_tile,
	output logic                           last_of_map
);
	import tmvg_pkg::*;

	localparam int unsigned CWX = (MAX_MAP_TILES_ACROSS > 1) ? $clog2(MAX_MAP_TILES_ACROSS) : 1;
	localparam int unsigned CWY = (MAX_MAP_TILES_DOWN > 1) ? $clog2(MAX_MAP_TILES_DOWN) : 1;
	localparam int unsigned CW_MAX = (CWX > CWY) ? CWX : CWY;
	localparam int unsigned CMP_W = (CW_MAX + 1 > CFG_W + 1) ? CW_MAX + 1 : CFG_W + 1;
	localparam int unsigned BW0 = (CW_MAX > TILE_INDEX_BITS) ? CW_MAX : TILE_INDEX_BITS;
	localparam int unsigned BW  = (BW0 > CFG_W) ? BW0 : CFG_W;
	localparam int unsigned PW  = CFG_W + BW;

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_DIV  = 4'b0010,
		S_MUL  = 4'b0100,
		S_EMIT = 4'b1000
	} state_t;

	typedef enum logic [1:0] {
		M_POS_X = 2'd0,
		M_POS_Y = 2'd1,
		M_TEX_U = 2'd2,
		M_TEX_V = 2'd3
	} mul_sel_t;

	state_t             state_q;
	mul_sel_t           mul_q;
	logic [CWX-1:0]     col_q;
	logic [CWY-1:0]     row_q;
	logic [CORNER_W-1:0] corner_q;
	logic [POS_W-1:0]   base_x_q;
	logic [POS_W-1:0]   base_y_q;
	logic [TEXU_W-1:0]  base_u_q;
	logic [TEXV_W-1:0]  base_v_q;

	logic               in_fire;
	logic               out_fire;
	logic [CFG_W-1:0]   mul_a;
	logic [BW-1:0]      mul_b;
	logic [PW-1:0]      prod;
	logic [CMP_W-1:0]   col_next;
	logic [CMP_W-1:0]   row_next;
	logic               col_wrap;
	logic               row_wrap;
	logic               map_end;
	logic [CFG_W-1:0]   dx;
	logic [CFG_W-1:0]   dy;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = (state_q == S_EMIT);
	assign in_fire   = in_valid && in_ready;
	assign out_fire  = out_valid && out_ready;
	assign div_start = in_fire;

	// Map position checks
	assign col_next = CMP_W'(col_q) + CMP_W'(1);
	assign row_next = CMP_W'(row_q) + CMP_W'(1);
	assign col_wrap = (col_next >= CMP_W'(cfg.mw));
	assign row_wrap = (row_next >= CMP_W'(cfg.mh));
	assign map_end  = col_wrap && row_wrap;

	// Shared multiplier operand select
	always_comb begin
		case (mul_q)
			M_POS_X: begin
				mul_a = cfg.tw;
				mul_b = BW'(col_q);
			end
			M_POS_Y: begin
				mul_a = cfg.th;
				mul_b = BW'(row_q);
			end
			M_TEX_U: begin
				mul_a = cfg.tw;
				mul_b = BW'(div_rem);
			end
			M_TEX_V: begin
				mul_a = cfg.th;
				mul_b = BW'(div_quo);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign prod = PW'(mul_a) * PW'(mul_b);

	// Sequencer and counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			mul_q    <= M_POS_X;
			corner_q <= '0;
			col_q    <= '0;
			row_q    <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_fire)
						state_q <= S_DIV;
				end
				S_DIV: begin
					if (div_stat.done) begin
						state_q <= S_MUL;
						mul_q   <= M_POS_X;
					end
				end
				S_MUL: begin
					if (mul_q == M_TEX_V) begin
						state_q  <= S_EMIT;
						corner_q <= '0;
					end else begin
						mul_q <= mul_sel_t'(mul_q + 2'd1);
					end
				end
				S_EMIT: begin
					if (out_fire) begin
						if (corner_q == LAST_CORNER) begin
							state_q <= S_IDLE;
							// step column, then row on wrap
							if (col_wrap) begin
								col_q <= '0;
								row_q <= row_wrap ? '0 : CWY'(row_next);
							end else begin
								col_q <= CWX'(col_next);
							end
						end else begin
							corner_q <= corner_q + CORNER_W'(1);
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Base coordinates from the shared multiplier
	always_ff @(posedge clk) begin
		if (state_q == S_MUL) begin
			case (mul_q)
				M_POS_X: base_x_q <= POS_W'(prod);
				M_POS_Y: base_y_q <= POS_W'(prod);
				M_TEX_U: base_u_q <= TEXU_W'(prod);
				M_TEX_V: base_v_q <= TEXV_W'(prod);
				default: ;
			endcase
		end
	end

	// Vertex fields for the current corner
	assign dx = corner_dx(corner_q) ? cfg.tw : '0;
	assign dy = corner_dy(corner_q) ? cfg.th : '0;

	assign corner       = corner_q;
	assign pos_x        = base_x_q + POS_W'(dx);
	assign pos_y        = base_y_q + POS_W'(dy);
	assign tex_u        = base_u_q + TEXU_W'(dx);
	assign tex_v        = base_v_q + TEXV_W'(dy);
	assign last_of_tile = (corner_q == LAST_CORNER);
	assign last_of_map  = (corner_q == LAST_CORNER) && map_end;

	`ASSERT_CLK(a_corner_range, out_valid |-> (corner_q <= LAST_CORNER),
		"corner beyond last vertex")
	`ASSERT_NEVER(a_div_done_idle, div_stat.done && (state_q != S_DIV),
		"divider finished outside the divide step")
	`ASSERT_CLK(a_tile_end_idle, (out_fire && last_of_tile) |=> in_ready,
		"not ready after the last vertex of a tile")
	`ASSERT_CLK(a_corner_step, (out_fire && !last_of_tile) |=>
		(corner_q == $past(corner_q) + CORNER_W'(1)) && out_valid,
		"corner did not advance after a taken vertex")

endmodule

[src/tile_map_vertex_generator_top.sv]
// Top level of the tile map vertex generator: ports, configuration registers, units.
//
// Each accepted tile number yields six vertices (two triangles, corners top-left, top-right,
// bottom-left, bottom-right, top-right, bottom-left) in row-major map order. The texture cell
// comes from a bit-serial divider that resolves one quotient bit per cycle, the four base
// coordinates then go one per cycle through a single shared multiplier, and the six vertices
// leave one per cycle while the output is not stalled. s_axis_tready is low until the sixth
// vertex has been taken.
// Configuration is taken on every cycle; write it only while no tile is in flight.

module tile_map_vertex_generator_top #(
	parameter int unsigned MAX_MAP_TILES_ACROSS = tmvg_pkg::DEF_MAX_MAP_TILES_ACROSS,
	parameter int unsigned MAX_MAP_TILES_DOWN   = tmvg_pkg::DEF_MAX_MAP_TILES_DOWN,
	parameter int unsigned TILE_INDEX_BITS      = tmvg_pkg::DEF_TILE_INDEX_BITS
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	// configuration writes
	input  logic                                    cfg_valid,
	output logic                                    cfg_ready,
	input  logic [tmvg_pkg::CFG_IDX_W-1:0]          cfg_index,
	input  logic [tmvg_pkg::CFG_W-1:0]              cfg_data,
	// tile number requests
	input  logic                                    s_axis_tvalid,
	output logic                                    s_axis_tready,
	input  logic [((TILE_INDEX_BITS+7)/8)*8-1:0]    s_axis_tdata,  // tile_number
	// vertices
	output logic                                    m_axis_tvalid,
	input  logic                                    m_axis_tready,
	// corner, pos_x, pos_y, tex_u, tex_v, zero fill
	output logic [tmvg_pkg::OUT_TDATA_W-1:0]        m_axis_tdata,
	output logic                                    m_axis_tlast,  // last_of_tile
	output logic                                    m_axis_tuser   // last_of_map
);
	import tmvg_pkg::*;

	logic [CFG_W-1:0] tile_width_q;
	logic [CFG_W-1:0] tile_height_q;
	logic [CFG_W-1:0] map_width_q;
	logic [CFG_W-1:0] map_height_q;
	logic [CFG_W-1:0] tex_per_row_q;

	cfg_t                       cfg;
	logic                       div_start;
	div_stat_t                  div_stat;
	logic [TILE_INDEX_BITS-1:0] div_quo;
	logic [CFG_W-1:0]           div_rem;

	logic [CORNER_W-1:0] corner;
	logic [POS_W-1:0]    pos_x;
	logic [POS_W-1:0]    pos_y;
	logic [TEXU_W-1:0]   tex_u;
	logic [TEXV_W-1:0]   tex_v;

	// Configuration registers; unknown indexes are dropped
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tile_width_q  <= RST_TILE_WIDTH;
			tile_height_q <= RST_TILE_HEIGHT;
			map_width_q   <= RST_MAP_WIDTH;
			map_height_q  <= RST_MAP_HEIGHT;
			tex_per_row_q <= RST_TEX_PER_ROW;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_TILE_WIDTH:  tile_width_q  <= cfg_data;
				REG_TILE_HEIGHT: tile_height_q <= cfg_data;
				REG_MAP_WIDTH:   map_width_q   <= cfg_data;
				REG_MAP_HEIGHT:  map_height_q  <= cfg_data;
				REG_TEX_PER_ROW: tex_per_row_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Effective values
	assign cfg.tw  = clamp_cfg(tile_width_q, TILE_SIZE_MAX);
	assign cfg.th  = clamp_cfg(tile_height_q, TILE_SIZE_MAX);
	assign cfg.mw  = clamp_cfg(map_width_q, MAX_MAP_TILES_ACROSS);
	assign cfg.mh  = clamp_cfg(map_height_q, MAX_MAP_TILES_DOWN);
	assign cfg.tpr = clamp_cfg(tex_per_row_q, TEX_ROW_MAX);

	tmvg_div #(
		.TILE_INDEX_BITS (TILE_INDEX_BITS)
	) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.dividend  (s_axis_tdata[TILE_INDEX_BITS-1:0]),
		.divisor   (cfg.tpr),
		.quotient  (div_quo),
		.remainder (div_rem),
		.stat      (div_stat)
	);

	tmvg_seq #(
		.MAX_MAP_TILES_ACROSS (MAX_MAP_TILES_ACROSS),
		.MAX_MAP_TILES_DOWN   (MAX_MAP_TILES_DOWN),
		.TILE_INDEX_BITS      (TILE_INDEX_BITS)
	) u_seq (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg),
		.in_valid     (s_axis_tvalid),
		.in_ready     (s_axis_tready),
		.div_start    (div_start),
		.div_stat     (div_stat),
		.div_quo      (div_quo),
		.div_rem      (div_rem),
		.out_valid    (m_axis_tvalid),
		.out_ready    (m_axis_tready),
		.corner       (corner),
		.pos_x        (pos_x),
		.pos_y        (pos_y),
		.tex_u        (tex_u),
		.tex_v        (tex_v),
		.last_of_tile (m_axis_tlast),
		.last_of_map  (m_axis_tuser)
	);

	// Pack vertex fields, lowest field first
	assign m_axis_tdata = OUT_TDATA_W'({tex_v, tex_u, pos_y, pos_x, corner});

endmodule

[dv/tb.sv]
`timescale 1ns / 100ps
// Testbench for the tile map vertex generator: directed and random tile streams, checked per vertex.
module tb;
	import tmvg_pkg::*;

	localparam int unsigned TILE_BITS    = DEF_TILE_INDEX_BITS;
	localparam int unsigned TILE_TDATA_W = ((TILE_BITS + 7) / 8) * 8;
	localparam logic [CFG_IDX_W-1:0] IDX_FIRST_UNUSED = CFG_IDX_W'(REG_TEX_PER_ROW) + 1'b1;
	// corners that sit one tile to the right / one tile down
	localparam bit [CORNERS-1:0] RIGHT_CORNERS  = 6'b011010;
	localparam bit [CORNERS-1:0] BOTTOM_CORNERS = 6'b101100;
	localparam int unsigned MAX_REPORTS = 10;

	// one vertex as the checker sees it
	typedef struct packed {
		logic [CORNER_W-1:0] corner;
		logic [POS_W-1:0]    pos_x;
		logic [POS_W-1:0]    pos_y;
		logic [TEXU_W-1:0]   tex_u;
		logic [TEXV_W-1:0]   tex_v;
		logic                last_of_tile;
		logic                last_of_map;
	} vertex_t;

	// m_axis_tdata layout, lowest field last
	typedef struct packed {
		logic [OUT_TDATA_W-OUT_BITS-1:0] fill;
		logic [TEXV_W-1:0]   tex_v;
		logic [TEXU_W-1:0]   tex_u;
		logic [POS_W-1:0]    pos_y;
		logic [POS_W-1:0]    pos_x;
		logic [CORNER_W-1:0] corner;
	} vertex_bus_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0] cfg_data = '0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [TILE_TDATA_W-1:0] s_axis_tdata = '0;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_axis_tdata;
	logic m_axis_tlast;
	logic m_axis_tuser;

	// predictor copy of registers and map counters
	logic [CFG_W-1:0] r_tile_w = RST_TILE_WIDTH;
	logic [CFG_W-1:0] r_tile_h = RST_TILE_HEIGHT;
	logic [CFG_W-1:0] r_map_w  = RST_MAP_WIDTH;
	logic [CFG_W-1:0] r_map_h  = RST_MAP_HEIGHT;
	logic [CFG_W-1:0] r_tpr    = RST_TEX_PER_ROW;
	logic [7:0] col_pos = '0;
	logic [7:0] row_pos = '0;

	vertex_t pending_vertices[$];
	int unsigned fail_count = 0;
	int unsigned tiles_sent = 0;
	int unsigned vertices_seen = 0;
	int unsigned settings_used = 0;
	int unsigned src_idle_pct = 0;
	int unsigned sink_stall_pct = 0;

	vertex_bus_t out_bus;
	vertex_t got_vtx;
	vertex_t want_vtx;

	tile_map_vertex_generator_top dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.m_axis_tuser  (m_axis_tuser)
	);

	always #5 clk = ~clk;

	// zero means one, above the limit means the limit
	function automatic int unsigned eff_size(logic [CFG_W-1:0] v, int unsigned hi);
		if (v == '0)
			return 1;
		if (int'(v) > hi)
			return hi;
		return int'(v);
	endfunction

	// expected six vertices of one tile, then step the map counters
	function automatic void queue_tile_vertices(logic [TILE_BITS-1:0] num);
		int unsigned tw, th, mw, mh, tpr, tile, bx, by, bu, bv, dx, dy, nxt_col, nxt_row;
		bit map_end;
		vertex_t v;
		tw = eff_size(r_tile_w, TILE_SIZE_MAX);
		th = eff_size(r_tile_h, TILE_SIZE_MAX);
		mw = eff_size(r_map_w, DEF_MAX_MAP_TILES_ACROSS);
		mh = eff_size(r_map_h, DEF_MAX_MAP_TILES_DOWN);
		tpr = eff_size(r_tpr, TEX_ROW_MAX);
		tile = int'(num);
		bx = tw * col_pos;
		by = th * row_pos;
		bu = tw * (tile % tpr);
		bv = th * (tile / tpr);
		map_end = (int'(col_pos) + 1 >= mw) && (int'(row_pos) + 1 >= mh);
		for (int k = 0; k < CORNERS; k++) begin
			dx = RIGHT_CORNERS[k] ? tw : 0;
			dy = BOTTOM_CORNERS[k] ? th : 0;
			v.corner = CORNER_W'(k);
			v.pos_x = POS_W'(bx + dx);
			v.pos_y = POS_W'(by + dy);
			v.tex_u = TEXU_W'(bu + dx);
			v.tex_v = TEXV_W'(bv + dy);
			v.last_of_tile = (k == CORNERS - 1);
			v.last_of_map = (k == CORNERS - 1) && map_end;
			pending_vertices.push_back(v);
		end
		// column wraps first, then row
		nxt_col = int'(col_pos) + 1;
		nxt_row = int'(row_pos);
		if (nxt_col >= mw) begin
			nxt_col = 0;
			nxt_row++;
			if (nxt_row >= mh)
				nxt_row = 0;
		end
		col_pos = 8'(nxt_col);
		row_pos = 8'(nxt_row);
	endfunction

	task automatic note_failure(string what);
		fail_count++;
		if (fail_count <= MAX_REPORTS)
			$display("[%0t] FAIL: %s", $realtime, what);
	endtask

	// vertex checker
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			out_bus = vertex_bus_t'(m_axis_tdata);
			got_vtx.corner = out_bus.corner;
			got_vtx.pos_x = out_bus.pos_x;
			got_vtx.pos_y = out_bus.pos_y;
			got_vtx.tex_u = out_bus.tex_u;
			got_vtx.tex_v = out_bus.tex_v;
			got_vtx.last_of_tile = m_axis_tlast;
			got_vtx.last_of_map = m_axis_tuser;
			vertices_seen++;
			if (pending_vertices.size() == 0) begin
				note_failure($sformatf("vertex with none expected: %p", got_vtx));
			end else begin
				want_vtx = pending_vertices.pop_front();
				if (got_vtx !== want_vtx)
					note_failure($sformatf("vertex mismatch: expected %p, got %p",
						want_vtx, got_vtx));
			end
		end
	end

	// output backpressure
	always @(posedge clk) begin
		m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
	end

	// one tile number request
	task automatic send_tile(logic [TILE_BITS-1:0] num);
		if ($urandom_range(99) < src_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < src_idle_pct);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= TILE_TDATA_W'(num);
		do @(posedge clk); while (!s_axis_tready);
		queue_tile_vertices(num);
		tiles_sent++;
	endtask

	// leaves cfg_valid high; caller lowers it after the last write
	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		case (reg_idx_t'(idx))
			REG_TILE_WIDTH:  r_tile_w = val;
			REG_TILE_HEIGHT: r_tile_h = val;
			REG_MAP_WIDTH:   r_map_w = val;
			REG_MAP_HEIGHT:  r_map_h = val;
			REG_TEX_PER_ROW: r_tpr = val;
			default: ;
		endcase
	endtask

	task automatic set_config(logic [CFG_W-1:0] tw, logic [CFG_W-1:0] th,
			logic [CFG_W-1:0] mw, logic [CFG_W-1:0] mh, logic [CFG_W-1:0] tpr);
		write_reg(REG_TILE_WIDTH, tw);
		write_reg(REG_TILE_HEIGHT, th);
		write_reg(REG_MAP_WIDTH, mw);
		write_reg(REG_MAP_HEIGHT, mh);
		write_reg(REG_TEX_PER_ROW, tpr);
		cfg_valid <= 1'b0;
		settings_used++;
	endtask

	// stop requests and wait for every expected vertex
	task automatic drain;
		s_axis_tvalid <= 1'b0;
		while (pending_vertices.size() != 0)
			@(posedge clk);
	endtask

	// register value: mostly in range, sometimes zero, one, the top or above it
	function automatic logic [CFG_W-1:0] pick_reg(int unsigned typical_hi);
		case ($urandom_range(9))
			0: return '0;
			1: return CFG_W'($urandom_range(511, 257));
			2: return CFG_W'(256);
			3: return CFG_W'(1);
			default: return CFG_W'($urandom_range(typical_hi, 1));
		endcase
	endfunction

	function automatic logic [TILE_BITS-1:0] pick_tile;
		case ($urandom_range(15))
			0: return '0;
			1: return '1;
			default: return TILE_BITS'($urandom);
		endcase
	endfunction

	// reset values, tile number extremes and alternating bits
	task automatic test_reset_defaults;
		send_tile('0);
		send_tile('1);
		send_tile(12'hAAA);
		send_tile(12'h555);
		drain();
	endtask

	// zero, above-range and full-scale register values
	task automatic test_config_extremes;
		set_config('0, '0, '0, '0, '0);
		send_tile('1);
		send_tile(12'h001);
		send_tile('0);
		drain();
		set_config('1, '1, '1, '1, '1);
		send_tile('1);
		send_tile(12'h0FF);
		send_tile(12'h100);
		drain();
		set_config(CFG_W'(256), CFG_W'(256), CFG_W'(256), CFG_W'(256), CFG_W'(1));
		send_tile('1);
		send_tile(12'h7FF);
		send_tile('0);
		drain();
	endtask

	// shrink the map under the live counters
	task automatic test_map_shrink;
		set_config(CFG_W'(8), CFG_W'(4), CFG_W'(8), CFG_W'(4), CFG_W'(3));
		for (int i = 0; i < 6; i++)
			send_tile(pick_tile());
		drain();
		set_config(CFG_W'(8), CFG_W'(4), CFG_W'(3), CFG_W'(1), CFG_W'(3));
		send_tile(12'h00B);
		send_tile(12'h00C);
		drain();
	endtask

	// writes to unmapped indexes change nothing
	task automatic test_unknown_index;
		for (int idx = IDX_FIRST_UNUSED; idx < (1 << CFG_IDX_W); idx++)
			write_reg(CFG_IDX_W'(idx), CFG_W'($urandom));
		cfg_valid <= 1'b0;
		send_tile(12'h123);
		send_tile(12'hEDC);
		drain();
	endtask

	// random configs and tiles under each pacing mode
	task automatic test_random_traffic;
		int unsigned idle_modes[4] = '{0, 76, 0, 38};
		int unsigned stall_modes[4] = '{0, 0, 76, 38};
		for (int p = 0; p < 4; p++) begin
			src_idle_pct = idle_modes[p];
			sink_stall_pct = stall_modes[p];
			for (int c = 0; c < 3; c++) begin
				set_config(pick_reg(256), pick_reg(256), pick_reg(6), pick_reg(5),
					pick_reg(64));
				for (int i = 0; i < 33; i++)
					send_tile(pick_tile());
				drain();
			end
		end
		src_idle_pct = 0;
		sink_stall_pct = 0;
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_defaults();
		test_config_extremes();
		test_map_shrink();
		test_unknown_index();
		test_random_traffic();
		drain();
		// let any stray vertex show up
		repeat (60) @(posedge clk);
		if (pending_vertices.size() != 0)
			note_failure($sformatf("%0d vertices never arrived", pending_vertices.size()));
		$display("Ran %0d tiles, checked %0d vertices over %0d register settings,",
			tiles_sent, vertices_seen, settings_used);
		$display("with and without input gaps and output backpressure; failures: %0d",
			fail_count);
		if (fail_count == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

	// watchdog
	initial begin
		#(5_000_000);
		$display("watchdog expired");
		$display("end of test: mismatches");
		$finish;
	end

endmodule
